@@ rtl/icy_pkg.sv @@
`timescale 1ns / 1ps

package icy_pkg;

  localparam int INTERVAL_BITS = 24;
  localparam int CONTENT_BITS = 32;
  localparam int META_LEFT_BITS = 12;
  localparam int META_UNIT_SHIFT = 4;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_META_INTERVAL = 2'd0,
    CFG_LIMIT_ENABLE = 2'd1,
    CFG_CONTENT_LENGTH = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    KIND_AUDIO = 3'd0,
    KIND_LEN = 3'd1,
    KIND_META = 3'd2,
    KIND_TITLE = 3'd3,
    KIND_DISC = 3'd4
  } kind_t;

  localparam logic [7:0] CHAR_EQUALS = 8'h3D;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;

  typedef struct packed {
    logic step;
    logic last;
    logic clear;
  } title_ctl_t;

  typedef struct packed {
    logic is_title;
    logic done;
  } title_res_t;

endpackage

@@ rtl/icy_stream_if.sv @@
`timescale 1ns / 1ps

interface icy_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface icy_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] kind;
  logic       title_done;

  modport source (output valid, output out_byte, output kind, output title_done, input ready);
  modport sink (input valid, input out_byte, input kind, input title_done, output ready);
endinterface

@@ rtl/icy_metadata_deframer.sv @@
`timescale 1ns / 1ps

// Inline ICY metadata deframer. Every body byte taken on in_ch comes out on
// out_ch from a registered output, tagged as audio, length byte, metadata, title
// character or discarded past the content limit, with title_done on the byte
// that closes a non-empty title. One byte per cycle is sustained: a single
// output register holds the tagged byte, and a new byte is taken whenever that
// register is empty or being read in the same cycle. Configuration is written
// through cfg_we/cfg_index/cfg_wdata while the stream is idle; a write of the
// interval register restarts the audio count and abandons any open block.

module icy_metadata_deframer
  import icy_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  icy_in_if.sink                in_ch,
  icy_out_if.source             out_ch
);

  typedef enum logic {
    PH_AUDIO = 1'b0,
    PH_META = 1'b1
  } phase_t;

  logic [INTERVAL_BITS-1:0]  meta_interval_r;
  logic                      limit_en_r;
  logic [CONTENT_BITS-1:0]   content_length_r;

  phase_t                    phase_r, phase_nxt;
  logic [INTERVAL_BITS-1:0]  audio_left_r, audio_left_nxt;
  logic [META_LEFT_BITS-1:0] meta_left_r, meta_left_nxt;
  logic [CONTENT_BITS-1:0]   delivered_r, delivered_nxt;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  kind_t      kind_r, kind_nxt;
  logic       done_r, done_nxt;

  logic                      accept;
  logic                      in_ready;
  logic                      past_end;
  logic [META_LEFT_BITS-1:0] meta_dec;
  logic                      meta_path;
  logic                      len_path;
  logic                      interval_wr;
  title_ctl_t                tctl;
  title_res_t                tres;

  assign in_ready = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready;
  assign accept = in_ch.valid && in_ready;
  assign past_end = limit_en_r && (delivered_r >= content_length_r);
  assign meta_dec = meta_left_r - 1'b1;
  assign interval_wr = cfg_we && (cfg_index == CFG_META_INTERVAL);

  always_comb begin
    phase_nxt = phase_r;
    audio_left_nxt = audio_left_r;
    meta_left_nxt = meta_left_r;
    delivered_nxt = delivered_r;
    kind_nxt = KIND_META;
    done_nxt = 1'b0;
    meta_path = 1'b0;
    len_path = 1'b0;
    priority if (past_end) begin
      kind_nxt = KIND_DISC;
    end else if (phase_r == PH_META) begin
      meta_path = 1'b1;
      meta_left_nxt = meta_dec;
      kind_nxt = tres.is_title ? KIND_TITLE : KIND_META;
      done_nxt = tres.done;
      if (meta_dec == '0) begin
        phase_nxt = PH_AUDIO;
        audio_left_nxt = meta_interval_r;
      end
    end else if (meta_interval_r == '0 || audio_left_r != '0) begin
      kind_nxt = KIND_AUDIO;
      if (meta_interval_r != '0) begin
        audio_left_nxt = audio_left_r - 1'b1;
      end
      delivered_nxt = delivered_r + 1'b1;
    end else begin
      len_path = 1'b1;
      kind_nxt = KIND_LEN;
      if (in_ch.in_byte == 8'd0) begin
        audio_left_nxt = meta_interval_r;
      end else begin
        meta_left_nxt = {in_ch.in_byte, META_UNIT_SHIFT'(0)};
        phase_nxt = PH_META;
      end
    end
  end

  assign tctl.step = accept && meta_path;
  assign tctl.last = (meta_dec == '0);
  assign tctl.clear = (accept && len_path) || interval_wr;

  icy_title u_title (
    .clk  (clk),
    .rst_n(rst_n),
    .data (in_ch.in_byte),
    .ctl  (tctl),
    .res  (tres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_interval_r <= '0;
      limit_en_r <= 1'b0;
      content_length_r <= '0;
      phase_r <= PH_AUDIO;
      audio_left_r <= '0;
      meta_left_r <= '0;
      delivered_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        audio_left_r <= audio_left_nxt;
        meta_left_r <= meta_left_nxt;
        delivered_r <= delivered_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_META_INTERVAL: begin
            meta_interval_r <= cfg_wdata[INTERVAL_BITS-1:0];
            audio_left_r <= cfg_wdata[INTERVAL_BITS-1:0];
            phase_r <= PH_AUDIO;
            meta_left_r <= '0;
          end
          CFG_LIMIT_ENABLE: begin
            limit_en_r <= cfg_wdata[0];
          end
          CFG_CONTENT_LENGTH: begin
            content_length_r <= cfg_wdata[CONTENT_BITS-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte_r <= in_ch.in_byte;
      kind_r <= kind_nxt;
      done_r <= done_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.kind = kind_r;
  assign out_ch.title_done = done_r;

endmodule

@@ rtl/icy_title.sv @@
`timescale 1ns / 1ps

module icy_title
  import icy_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] data,
  input  title_ctl_t ctl,
  output title_res_t res
);

  typedef enum logic [1:0] {
    TP_BEFORE = 2'd0,
    TP_IN = 2'd1,
    TP_AFTER = 2'd2
  } tphase_t;

  tphase_t tphase_r, tphase_nxt;
  logic    seen_r, seen_nxt;

  always_comb begin
    tphase_nxt = tphase_r;
    seen_nxt = seen_r;
    res = '0;
    unique case (tphase_r)
      TP_BEFORE: begin
        if (data == CHAR_EQUALS) begin
          tphase_nxt = TP_IN;
        end
      end
      TP_IN: begin
        if (data == CHAR_SEMI) begin
          tphase_nxt = TP_AFTER;
          res.done = seen_r;
        end else begin
          res.is_title = 1'b1;
          seen_nxt = 1'b1;
          res.done = ctl.last;
        end
      end
      TP_AFTER: begin
      end
      default: begin
        tphase_nxt = tphase_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tphase_r <= TP_BEFORE;
      seen_r <= 1'b0;
    end else if (ctl.clear) begin
      tphase_r <= TP_BEFORE;
      seen_r <= 1'b0;
    end else if (ctl.step) begin
      tphase_r <= tphase_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

@@ rtl/icy_checker.sv @@
`timescale 1ns / 1ps

module icy_checker
  import icy_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [2:0] kind,
  input logic       title_done
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(kind)
      && $stable(title_done))
    else $error("stalled item changed");

  // accepted byte appears next cycle unchanged
  a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid && out_byte == $past(in_byte))
    else $error("byte not passed through");

  // single output stage: no new item while a result is stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("item taken while output stalled");

  // title close only on metadata bytes
  a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && title_done |-> kind == KIND_TITLE || kind == KIND_META)
    else $error("title_done on non-metadata item");

endmodule

bind icy_metadata_deframer icy_checker u_icy_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_byte   (in_ch.in_byte),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .kind      (out_ch.kind),
  .title_done(out_ch.title_done)
);
